>>> rtl/mdf_pkg.sv
// Shared types and constants of the mirrored downscale framer.
`timescale 1ns / 1ps
`default_nettype none

package mdf_pkg;

  // Input beat action codes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned CfgWidth   = 8;
  localparam int unsigned PixWidth   = 24;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned AccWidth   = 10;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic [CfgWidth-1:0] SizeReset = 8'd128;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_EMIT
  } state_e;

  // Control of the shared accumulate unit.
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/mdf_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mdf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mdf_apb_regs.sv
// APB configuration registers and effective frame size clamp.
`timescale 1ns / 1ps
`default_nettype none

module mdf_apb_regs
  import mdf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ApbAddrW-1:0]               paddr,
  input  wire logic [ApbDataW-1:0]               pwdata,
  output logic      [ApbDataW-1:0]               prdata,
  output logic                                   pready,
  output logic      [$clog2(MAX_WIDTH+1)-1:0]    width_eff_o,
  output logic      [$clog2(MAX_HEIGHT+1)-1:0]   height_eff_o
);

  localparam int unsigned SWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SHW = $clog2(MAX_HEIGHT + 1);

  logic [CfgWidth-1:0] width_q, width_d;
  logic [CfgWidth-1:0] height_q, height_d;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  width_d  = pwdata[CfgWidth-1:0];
        REG_FRAME_HEIGHT: height_d = pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeReset;
      height_q <= SizeReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = ApbDataW'(width_q);
      REG_FRAME_HEIGHT: prdata = ApbDataW'(height_q);
      default:          prdata = '0;
    endcase
  end

  // Zero acts as one, anything above the maximum acts as the maximum.
  always_comb begin
    if (width_q == '0) begin
      width_eff_o = SWW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      width_eff_o = SWW'(MAX_WIDTH);
    end else begin
      width_eff_o = SWW'(width_q);
    end
    if (height_q == '0) begin
      height_eff_o = SHW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      height_eff_o = SHW'(MAX_HEIGHT);
    end else begin
      height_eff_o = SHW'(height_q);
    end
  end

endmodule

`default_nettype wire

>>> rtl/mdf_accum.sv
// Shared per-channel accumulate unit for the 2x2 block average.
`timescale 1ns / 1ps
`default_nettype none

module mdf_accum
  import mdf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire acc_ctrl_t           ctrl_i,
  input  wire logic                single_i,
  input  wire logic [PixWidth-1:0] pixel_i,
  output logic      [PixWidth-1:0] result_o
);

  logic [AccWidth-1:0] acc_q [3];
  logic [AccWidth-1:0] acc_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = acc_q[c];
      if (ctrl_i.clear) begin
        acc_d[c] = '0;
      end else if (ctrl_i.add) begin
        acc_d[c] = acc_q[c] + AccWidth'(pixel_i[c*ChanWidth +: ChanWidth]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_d[c];
      end
    end
  end

  // Single pixel passes through; four pixels drop two bits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      result_o[c*ChanWidth +: ChanWidth] = single_i ? acc_q[c][ChanWidth-1:0]
                                                    : acc_q[c][AccWidth-1:2];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mirrored_downscale_framer.sv
// Top level of the mirrored downscale framer: sequencer, counters and wiring.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid_i / in_ready_o): each beat carries action_i and a
//   source pixel. A load beat (action 0) writes the pixel at the load counter
//   in raster order and produces no output. A request beat (action 1) yields
//   one output beat: the next pixel of the output frame in raster order,
//   with frame_end_o set on its last pixel.
//   Output channel (out_valid_o / out_ready_i): one registered beat. A load
//   beat is still taken while an output beat waits; a request finishes its
//   reads and then holds until the output register is free.
//   Steps per beat: a load beat writes the frame memory and leaves the
//   sequencer idle. A request outside the center half goes straight to emit;
//   one inside reads one source pixel, or four for a 2x2 block, one read per
//   cycle of the single-port frame memory, then drains to add the last read
//   and emits. The memory port and the shared accumulate unit set these steps.
//   Configuration: frame_width at byte address 0, frame_height at 4, over
//   the APB port; write only while the block is idle.
//   Reset: counters clear, sizes return to 128, the frame memory is not
//   cleared and must be loaded before it is read.
module mirrored_downscale_framer
  import mdf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ApbAddrW-1:0]  paddr,
  input  wire logic [ApbDataW-1:0]  pwdata,
  output logic      [ApbDataW-1:0]  prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 action_i,
  input  wire logic [ChanWidth-1:0] in_red_i,
  input  wire logic [ChanWidth-1:0] in_green_i,
  input  wire logic [ChanWidth-1:0] in_blue_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [ChanWidth-1:0] out_red_o,
  output logic      [ChanWidth-1:0] out_green_o,
  output logic      [ChanWidth-1:0] out_blue_o,
  output logic                      frame_end_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned SWW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SHW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = 2 ** AW;

  // Effective frame size from the register block.
  logic [SWW-1:0] w_eff;
  logic [SHW-1:0] h_eff;

  mdf_apb_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .width_eff_o  (w_eff),
    .height_eff_o (h_eff)
  );

  state_e state_q, state_d;

  logic [RW-1:0] ld_row_q, ld_row_d, em_row_q, em_row_d;
  logic [CW-1:0] ld_col_q, ld_col_d, em_col_q, em_col_d;
  logic [RW-1:0] sr_q;
  logic [CW-1:0] sc_q;
  logic          single_q, white_q, fend_q;
  logic [1:0]    rd_k_q;
  logic          rd_pend_q;

  logic [ChanWidth-1:0] out_red_q, out_green_q, out_blue_q;
  logic                 out_valid_q, out_fend_q;

  logic in_accept, load_acc, req_acc, out_free, out_load, rd_last, ram_re;
  acc_ctrl_t acc_ctrl;

  assign in_accept = in_valid_i & in_ready_o;
  assign load_acc  = in_accept & (action_i == ACT_LOAD);
  assign req_acc   = in_accept & (action_i == ACT_REQUEST);
  assign out_free  = ~out_valid_q | out_ready_i;

  // Counter clamp: a counter at or beyond its size is taken as zero.
  logic [RW-1:0] ld_row_use, em_row_use;
  logic [CW-1:0] ld_col_use, em_col_use;

  assign ld_row_use = (SHW'(ld_row_q) >= h_eff) ? '0 : ld_row_q;
  assign ld_col_use = (SWW'(ld_col_q) >= w_eff) ? '0 : ld_col_q;
  assign em_row_use = (SHW'(em_row_q) >= h_eff) ? '0 : em_row_q;
  assign em_col_use = (SWW'(em_col_q) >= w_eff) ? '0 : em_col_q;

  // Raster advance of both counter pairs.
  logic ld_col_wrap, ld_row_wrap, em_col_wrap, em_row_wrap;

  assign ld_col_wrap = (SWW'(ld_col_use) + SWW'(1)) >= w_eff;
  assign ld_row_wrap = (SHW'(ld_row_use) + SHW'(1)) >= h_eff;
  assign em_col_wrap = (SWW'(em_col_use) + SWW'(1)) >= w_eff;
  assign em_row_wrap = (SHW'(em_row_use) + SHW'(1)) >= h_eff;

  always_comb begin
    ld_row_d = ld_row_q;
    ld_col_d = ld_col_q;
    em_row_d = em_row_q;
    em_col_d = em_col_q;
    if (load_acc) begin
      if (ld_col_wrap) begin
        ld_col_d = '0;
        ld_row_d = ld_row_wrap ? '0 : RW'(ld_row_use + RW'(1));
      end else begin
        ld_row_d = ld_row_use;
        ld_col_d = CW'(ld_col_use + CW'(1));
      end
    end
    if (req_acc) begin
      if (em_col_wrap) begin
        em_col_d = '0;
        em_row_d = em_row_wrap ? '0 : RW'(em_row_use + RW'(1));
      end else begin
        em_row_d = em_row_use;
        em_col_d = CW'(em_col_use + CW'(1));
      end
    end
  end

  // Output pixel geometry: center-half test, fold, source corner.
  logic [SHW-1:0] y_ext, h_lo, h_hi, h_m1, y_mir, fold_a;
  logic [SWW-1:0] x_ext, w_lo, w_hi, w_m1, x_mir, fold_b;
  logic [RW-1:0]  sr_w;
  logic [CW-1:0]  sc_w;
  logic           inside_w, single_w, fend_w;

  assign y_ext  = SHW'(em_row_use);
  assign x_ext  = SWW'(em_col_use);
  assign h_lo   = h_eff >> 2;
  assign w_lo   = w_eff >> 2;
  assign h_hi   = SHW'(({2'b00, h_eff} + {1'b0, h_eff, 1'b0}) >> 2);
  assign w_hi   = SWW'(({2'b00, w_eff} + {1'b0, w_eff, 1'b0}) >> 2);
  assign h_m1   = h_eff - SHW'(1);
  assign w_m1   = w_eff - SWW'(1);
  assign y_mir  = h_m1 - y_ext;
  assign x_mir  = w_m1 - x_ext;
  assign fold_a = (y_ext < y_mir) ? y_ext : y_mir;
  assign fold_b = (x_ext < x_mir) ? x_ext : x_mir;
  assign sr_w   = RW'({fold_a, 1'b0});
  assign sc_w   = CW'({fold_b, 1'b0});

  assign inside_w = (y_ext >= h_lo) && (y_ext < h_hi) && (x_ext >= w_lo) && (x_ext < w_hi);
  assign single_w = (SHW'(sr_w) == h_m1) || (SWW'(sc_w) == w_m1);
  assign fend_w   = (y_ext == h_m1) && (x_ext == w_m1);

  // Read walk: bit 0 of the index steps the row, bit 1 the column.
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;

  assign rd_row  = rd_k_q[0] ? RW'(sr_q + RW'(1)) : sr_q;
  assign rd_col  = rd_k_q[1] ? CW'(sc_q + CW'(1)) : sc_q;
  assign rd_last = single_q ? (rd_k_q == 2'd0) : (rd_k_q == 2'd3);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = inside_w ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        if (rd_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o     = 1'b0;
    ram_re         = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_READ:  ram_re     = 1'b1;
      S_DRAIN: ;
      S_EMIT:  out_load   = out_free;
      default: ;
    endcase
    acc_ctrl.clear = req_acc;
    acc_ctrl.add   = rd_pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      em_row_q    <= '0;
      em_col_q    <= '0;
      rd_k_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ld_row_q  <= ld_row_d;
      ld_col_q  <= ld_col_d;
      em_row_q  <= em_row_d;
      em_col_q  <= em_col_d;
      rd_pend_q <= ram_re;
      if (req_acc) begin
        rd_k_q <= '0;
      end else if (ram_re) begin
        rd_k_q <= rd_k_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-request geometry, held through the read walk.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      sr_q     <= sr_w;
      sc_q     <= sc_w;
      single_q <= single_w;
      white_q  <= ~inside_w;
      fend_q   <= fend_w;
    end
  end

  // Frame memory: load beats write, the read walk reads.
  logic [AW-1:0]       ram_addr;
  logic [PixWidth-1:0] ram_rdata, acc_result;

  assign ram_addr = ram_re ? {rd_row, rd_col} : {ld_row_use, ld_col_use};

  mdf_ram #(
    .WIDTH (PixWidth),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .rdata_o (ram_rdata)
  );

  mdf_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .single_i (single_q),
    .pixel_i  (ram_rdata),
    .result_o (acc_result)
  );

  // Output register: white outside the center half.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_red_q   <= white_q ? '1 : acc_result[2*ChanWidth +: ChanWidth];
      out_green_q <= white_q ? '1 : acc_result[ChanWidth +: ChanWidth];
      out_blue_q  <= white_q ? '1 : acc_result[0 +: ChanWidth];
      out_fend_q  <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_red_q;
  assign out_green_o = out_green_q;
  assign out_blue_o  = out_blue_q;
  assign frame_end_o = out_fend_q;

  // A load beat never leaves the sequencer busy.
  a_load_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> (state_q == S_IDLE))
    else $error("load beat left the sequencer busy");

  // Emitting with a free output register returns to idle with a beat shown.
  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && out_free |=> (state_q == S_IDLE) && out_valid_o)
    else $error("emit did not present an output beat");

  // The last read must be added in the drain cycle.
  a_drain_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> rd_pend_q && ($past(state_q) == S_READ))
    else $error("drain without a pending read");

  // A single-pixel walk issues exactly one read.
  a_single_one_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) && single_q |-> (rd_k_q == 2'd0))
    else $error("single-pixel walk issued more than one read");

endmodule

`default_nettype wire
